FILE: rtl/core/ptdt_pkg.sv
// Package for the trial-division primality test core.
// Holds widths and derived constants; used by the request interface, the core and the testbench.
package ptdt_pkg;

    localparam int CAND_W     = 32;
    localparam int DATA_WIDTH = 32;
    localparam int REM_W      = DATA_WIDTH + 1;
    localparam int SQ_W       = DATA_WIDTH + 2;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] DIV_FIRST = DATA_WIDTH'(5);
    localparam logic [DATA_WIDTH-1:0] DIV_THREE = DATA_WIDTH'(3);
    localparam logic [DATA_WIDTH-1:0] DIV_STEP  = DATA_WIDTH'(6);
    localparam logic [DATA_WIDTH-1:0] DIV_PAIR  = DATA_WIDTH'(2);
    localparam logic [SQ_W-1:0] SQ_FIRST  = SQ_W'(25);
    localparam logic [SQ_W-1:0] SQ_CONST  = SQ_W'(36);

    typedef logic signed [CAND_W-1:0] cand_t;

endpackage

FILE: rtl/core/ptdt_cand_if.sv
// Request channel carrying one candidate to the primality test core.
// Depends on ptdt_pkg for the candidate type.
interface ptdt_cand_if;
    import ptdt_pkg::*;

    logic  valid;
    logic  ready;
    cand_t candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

FILE: rtl/core/ptdt_res_if.sv
// Result channel carrying one primality verdict from the core.
// Stands alone; no package items are needed.
interface ptdt_res_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink (input valid, input is_prime, output ready);
endinterface

FILE: rtl/core/prime_trial_division_test_core.sv
// Trial-division primality test core with one shared bit-serial remainder unit.
// Depends on ptdt_pkg, ptdt_cand_if and ptdt_res_if.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------
//  cand    | in        | candidate, signed 32 bits
//  res     | out       | is_prime, 1 bit
//
// Every remainder is formed bit-serially in the shared restoring divider.
// Trivial candidates get their verdict registered straight from the accept; others are tested by
// three and then by each divisor pair d, d + 2, with d from 5 in steps of 6, up to sqrt(n).
// Reset clears the sequencer and the result register; no clearing pass is needed.
// A new request is taken only while the sequencer is idle and the result slot is free.
module prime_trial_division_test_core (
    input logic clk,
    input logic rst_n,
    ptdt_cand_if.sink cand,
    ptdt_res_if.source res
);
    import ptdt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOP,
        S_DIV
    } state_t;

    typedef enum logic [1:0] {
        PH_THREE,
        PH_D,
        PH_D2
    } phase_t;

    state_t                state_reg;
    phase_t                phase_reg;
    logic [DATA_WIDTH-1:0] n_reg;
    logic [DATA_WIDTH-1:0] d_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DATA_WIDTH-1:0] div_reg;
    logic [DATA_WIDTH-1:0] q_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  out_valid_reg;
    logic                  out_prime_reg;

    logic [DATA_WIDTH-1:0] n_in;
    logic [REM_W-1:0]      trial;
    logic [REM_W-1:0]      rem_next;
    logic [SQ_W-1:0]       sq_next;
    logic                  slot_free;
    logic                  accept;

    assign n_in      = cand.candidate[DATA_WIDTH-1:0];
    assign slot_free = !out_valid_reg || res.ready;
    assign cand.ready = (state_reg == S_IDLE) && slot_free;
    assign accept    = cand.valid && cand.ready;

    assign res.valid    = out_valid_reg;
    assign res.is_prime = out_prime_reg;

    always_comb
    begin
        trial = {rem_reg[DATA_WIDTH-1:0], q_reg[DATA_WIDTH-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = trial - {1'b0, div_reg};
        end
        else
        begin
            rem_next = trial;
        end
        sq_next = sq_reg + {2'b00, d_reg[DATA_WIDTH-4:0], 3'b000}
                + {1'b0, d_reg[DATA_WIDTH-2:0], 2'b00} + SQ_CONST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_THREE;
            out_valid_reg <= 1'b0;
            out_prime_reg <= 1'b0;
            n_reg         <= '0;
            d_reg         <= '0;
            sq_reg        <= '0;
            div_reg       <= '0;
            q_reg         <= '0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        n_reg <= n_in;
                        if (n_in[DATA_WIDTH-1] || (n_in <= DATA_WIDTH'(1)))
                        begin
                            out_valid_reg <= 1'b1;
                            out_prime_reg <= 1'b0;
                        end
                        else if (n_in <= DIV_THREE)
                        begin
                            out_valid_reg <= 1'b1;
                            out_prime_reg <= 1'b1;
                        end
                        else if (!n_in[0])
                        begin
                            out_valid_reg <= 1'b1;
                            out_prime_reg <= 1'b0;
                        end
                        else
                        begin
                            phase_reg <= PH_THREE;
                            div_reg   <= DIV_THREE;
                            q_reg     <= n_in;
                            rem_reg   <= '0;
                            cnt_reg   <= CNT_LAST;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_LOOP:
                begin
                    if (sq_reg > {2'b00, n_reg})
                    begin
                        out_valid_reg <= 1'b1;
                        out_prime_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        phase_reg <= PH_D;
                        div_reg   <= d_reg;
                        q_reg     <= n_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= CNT_LAST;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    q_reg   <= {q_reg[DATA_WIDTH-2:0], 1'b0};
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        if (rem_next == '0)
                        begin
                            out_valid_reg <= 1'b1;
                            out_prime_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_THREE:
                                begin
                                    d_reg     <= DIV_FIRST;
                                    sq_reg    <= SQ_FIRST;
                                    state_reg <= S_LOOP;
                                end
                                PH_D:
                                begin
                                    phase_reg <= PH_D2;
                                    div_reg   <= d_reg + DIV_PAIR;
                                    q_reg     <= n_reg;
                                    rem_reg   <= '0;
                                    cnt_reg   <= CNT_LAST;
                                end
                                PH_D2:
                                begin
                                    d_reg     <= d_reg + DIV_STEP;
                                    sq_reg    <= sq_next;
                                    state_reg <= S_LOOP;
                                end
                                default:
                                begin
                                    state_reg <= S_IDLE;
                                end
                            endcase
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/prime_trial_division_test_core_tb.sv
// Self-checking testbench for prime_trial_division_test_core: drives candidates on the
// request channel and checks each verdict against a predictor of the trial-division test.
// Depends on ptdt_pkg, ptdt_cand_if, ptdt_res_if and the core itself.
`timescale 1ns / 1ps

module prime_trial_division_test_core_tb;
    import ptdt_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3_000_000;
    localparam int unsigned HOLD_CYCLES = 2000;
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int DIRECTED_COUNT = 21;
    localparam cand_t DIRECTED[DIRECTED_COUNT] = '{
        32'sh80000000, -32'sd1, 32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd9,
        32'sd5, 32'sd7, 32'sd25, 32'sd35, 32'sd49, 32'sd121, 32'sd10403, 32'sd10007,
        32'sd65521, 32'sd1018081, 32'sd1000003, 32'sh7FFFFFFE, 32'sh7FFFFFFF
    };

    typedef struct {
        cand_t candidate;
        logic  is_prime;
    } verdict_t;

    logic clk;
    logic rst_n;

    ptdt_cand_if cand_ch();
    ptdt_res_if res_ch();

    prime_trial_division_test_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_ch),
        .res   (res_ch)
    );

    cand_t       candidate_q[$];
    verdict_t    verdict_q[$];
    bit          no_idle;
    int unsigned hold_requests;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned send_gap;
    int unsigned quiet_cycles;
    int unsigned request_cnt;
    int unsigned verdict_cnt;
    int unsigned prime_cnt;
    int unsigned mismatch_cnt;
    verdict_t    oldest;

    function automatic logic prime_verdict(cand_t c);
        logic [63:0] n;
        logic [63:0] d;
        n = '0;
        n[DATA_WIDTH-1:0] = c[DATA_WIDTH-1:0];
        if (n[DATA_WIDTH-1])
            return 1'b0;
        if (n <= 64'd1)
            return 1'b0;
        if (n <= 64'(DIV_THREE))
            return 1'b1;
        if (n % 64'(DIV_PAIR) == 0 || n % 64'(DIV_THREE) == 0)
            return 1'b0;
        for (d = 64'(DIV_FIRST); d * d <= n; d += 64'(DIV_STEP))
        begin
            if (n % d == 0 || n % (d + 64'(DIV_PAIR)) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    function automatic cand_t random_candidate();
        int unsigned factors[6] = '{2, 3, 5, 7, 11, 13};
        int unsigned kind;
        logic [31:0] raw;
        kind = $urandom_range(0, 99);
        raw = $urandom;
        if (kind < 35)
            return cand_t'($urandom_range(0, 4095));
        else if (kind < 55)
            return cand_t'($urandom_range(4096, 262143));
        else if (kind < 75)
            return cand_t'({1'b1, raw[30:0]});
        raw[31] = 1'b0;
        raw = raw - raw % factors[$urandom_range(0, 5)];
        return cand_t'(raw);
    endfunction

    task automatic report_mismatch(string what, cand_t c, logic got, logic want);
        $display("MISMATCH %s: candidate %0d gave is_prime %b, expected %b",
                 what, c, got, want);
        mismatch_cnt++;
    endtask

    task automatic wait_drained();
        while (candidate_q.size() != 0 || cand_ch.valid || verdict_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_candidate(cand_t c);
        candidate_q.insert(candidate_q.size(), c);
    endtask

    task automatic queue_random(int unsigned count);
        repeat (count) add_candidate(random_candidate());
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cand_ch.valid = 1'b0;
        cand_ch.candidate = '0;
        res_ch.ready = 1'b0;
        fork
            forever #5 clk = ~clk;
            begin
                repeat (8) @(posedge clk);
                rst_n <= 1'b1;
            end
        join
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_ch.valid <= 1'b0;
            cand_ch.candidate <= '0;
            send_gap = 0;
        end
        else
        begin
            if (cand_ch.valid && cand_ch.ready)
            begin
                verdict_q.insert(verdict_q.size(),
                                 '{cand_ch.candidate, prime_verdict(cand_ch.candidate)});
                request_cnt++;
            end
            if (!cand_ch.valid || cand_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cand_ch.valid <= 1'b0;
                end
                else if (candidate_q.size() > 0)
                begin
                    cand_ch.valid <= 1'b1;
                    cand_ch.candidate <= candidate_q.pop_front();
                    send_gap = no_idle ? 0 : idle_length();
                end
                else
                    cand_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                verdict_cnt++;
                if (verdict_q.size() == 0)
                    report_mismatch("result with no pending request", '0, res_ch.is_prime, 1'bx);
                else
                begin
                    oldest = verdict_q.pop_front();
                    if (oldest.is_prime)
                        prime_cnt++;
                    if (res_ch.is_prime !== oldest.is_prime)
                        report_mismatch("wrong verdict", oldest.candidate, res_ch.is_prime,
                                        oldest.is_prime);
                end
            end
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                stall_left = no_idle ? 0 : idle_length();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
            $display("prime_trial_division_test_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        no_idle = 1'b0;
        hold_requests = 0;
        hold_seen = 0;
        quiet_cycles = 0;
        request_cnt = 0;
        verdict_cnt = 0;
        prime_cnt = 0;
        mismatch_cnt = 0;
        @(posedge rst_n);
        @(negedge clk);

        foreach (DIRECTED[i])
            add_candidate(DIRECTED[i]);
        wait_drained();

        queue_random(30);
        wait_drained();

        // The receiver holds off long enough for the core to fill and refuse requests.
        hold_requests++;
        no_idle = 1'b1;
        repeat (6) add_candidate(cand_t'($urandom_range(0, 255)));
        wait_drained();

        queue_random(15);
        wait_drained();

        no_idle = 1'b0;
        queue_random(28);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Checked %0d verdicts for %0d requests, %0d of them prime.",
                 verdict_cnt, request_cnt, prime_cnt);
        $display("Stimulus spanned negative, trivial, small, composite and the largest prime.");
        if (mismatch_cnt == 0)
            $display("prime_trial_division_test_core regression: pass");
        else
            $display("prime_trial_division_test_core regression: fail");
        $finish;
    end

endmodule

FILE: prime_trial_division_test_core.f
rtl/core/ptdt_pkg.sv
rtl/core/ptdt_cand_if.sv
rtl/core/ptdt_res_if.sv
rtl/core/prime_trial_division_test_core.sv
sim/prime_trial_division_test_core_tb.sv
